// ----- hdl/console_command_tokenizer_top_macros.svh -----
// Assertion macros for the console command tokenizer checker.
// Needs clk_i and rst_ni in the scope that uses them.
`ifndef CONSOLE_COMMAND_TOKENIZER_TOP_MACROS_SVH
`define CONSOLE_COMMAND_TOKENIZER_TOP_MACROS_SVH

// Clocked property, switched off while reset is held
`define CCT_PROP(p) @(posedge clk_i) disable iff (!rst_ni) (p)

// Labelled concurrent assertion that reports through $error
`define CCT_ASSERT(lbl, p, msg) \
  lbl: assert property (`CCT_PROP(p)) else $error(msg);

`endif

// ----- hdl/cct_pkg.sv -----
// Shared types, character codes and the per-byte tokenizer step functions.
// No dependencies; used by the decoder, the top level and the checker.
`timescale 1ns / 1ps

package cct_pkg;

  localparam int EvtMax    = 4;
  localparam int EvtIdxW   = $clog2(EvtMax);
  localparam int EvtCntW   = $clog2(EvtMax + 1);
  localparam int FifoDepth = 8;
  localparam int FifoPtrW  = $clog2(FifoDepth);
  localparam int FifoCntW  = $clog2(FifoDepth + 1);

  // Event kinds
  localparam logic [1:0] KIND_CHAR        = 2'd0;
  localparam logic [1:0] KIND_TOKEN_END   = 2'd1;
  localparam logic [1:0] KIND_COMMAND_END = 2'd2;

  // Character codes
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] ch;
    logic       last;
  } evt_t;

  typedef struct packed {
    logic quote_open;
    logic token_open;
    logic command_open;
    logic slash_waiting;
    logic comment_skip;
  } tok_state_t;

  typedef struct packed {
    tok_state_t              st;
    evt_t [EvtMax-1:0]       evt;
    logic [EvtCntW-1:0]      n;
  } work_t;

  function automatic logic is_white(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  // Append one event while there is room
  function automatic work_t emit(input work_t w, input logic [1:0] kind,
                                 input logic [7:0] ch);
    work_t r;
    r = w;
    if (r.n < EvtCntW'(EvtMax)) begin
      r.evt[r.n[EvtIdxW-1:0]] = '{kind: kind, ch: ch, last: 1'b0};
      r.n = r.n + EvtCntW'(1);
    end
    return r;
  endfunction

  function automatic work_t token_char(input work_t w, input logic [7:0] c);
    work_t r;
    r = emit(w, KIND_CHAR, c);
    r.st.token_open = 1'b1;
    return r;
  endfunction

  function automatic work_t end_token(input work_t w);
    work_t r;
    r = w;
    if (r.st.token_open) begin
      r = emit(r, KIND_TOKEN_END, 8'h00);
      r.st.command_open = 1'b1;
    end
    r.st.token_open = 1'b0;
    return r;
  endfunction

  function automatic work_t end_command(input work_t w);
    work_t r;
    r = end_token(w);
    if (r.st.command_open) begin
      r = emit(r, KIND_COMMAND_END, 8'h00);
    end
    r.st.command_open = 1'b0;
    return r;
  endfunction

  // Byte handling once slash and comment handling is settled
  function automatic work_t plain_byte(input work_t w, input logic [7:0] c);
    work_t r;
    r = w;
    if (r.st.quote_open) begin
      if ((c == CH_QUOTE) || (c == CH_NL)) begin
        r.st.quote_open = 1'b0;
      end
      if (c == CH_NL) begin
        r = end_command(r);
      end else if (c != CH_QUOTE) begin
        r = emit(r, KIND_CHAR, c);
      end
    end else if (c == CH_QUOTE) begin
      r.st.quote_open = 1'b1;
      r.st.token_open = 1'b1;
    end else if ((c == CH_SEMI) || (c == CH_NL)) begin
      r = end_command(r);
    end else if (is_white(c)) begin
      r = end_token(r);
    end else begin
      r = token_char(r, c);
    end
    return r;
  endfunction

endpackage

// ----- hdl/cct_decode.sv -----
// Per-byte decoder: next tokenizer state and up to four events per byte.
// Depends on cct_pkg.
`timescale 1ns / 1ps

module cct_decode (
  input  cct_pkg::tok_state_t                  state_i,
  input  logic [7:0]                           char_i,
  input  logic                                 last_i,
  output cct_pkg::tok_state_t                  next_state_o,
  output cct_pkg::evt_t [cct_pkg::EvtMax-1:0]  evt_o,
  output logic [cct_pkg::EvtCntW-1:0]          evt_cnt_o
);
  import cct_pkg::*;

  work_t              w;
  logic [EvtIdxW-1:0] last_idx;

  always_comb begin
    w.st  = state_i;
    w.evt = '0;
    w.n   = '0;

    // Resolve comment skip and pending slash first
    if (w.st.comment_skip) begin
      if (char_i == CH_NL) begin
        w.st.comment_skip = 1'b0;
        w = plain_byte(w, char_i);
      end
    end else if (w.st.slash_waiting) begin
      w.st.slash_waiting = 1'b0;
      if (char_i == CH_SLASH) begin
        w.st.comment_skip = 1'b1;
      end else begin
        w = token_char(w, CH_SLASH);
        w = plain_byte(w, char_i);
      end
    end else if (!w.st.quote_open && (char_i == CH_SLASH) && !last_i) begin
      w.st.slash_waiting = 1'b1;
    end else begin
      w = plain_byte(w, char_i);
    end

    // Flush everything at the end of the text
    if (last_i) begin
      w = end_command(w);
      w.st = '0;
    end

    // Mark the final event of this byte
    last_idx = w.n[EvtIdxW-1:0] - EvtIdxW'(1);
    if (w.n != '0) begin
      w.evt[last_idx].last = 1'b1;
    end
  end

  assign next_state_o = w.st;
  assign evt_o        = w.evt;
  assign evt_cnt_o    = w.n;

endmodule

// ----- hdl/console_command_tokenizer_top.sv -----
// The events of a taken byte are registered into the event queue and can appear on the output in the next cycle.
// Throughput: one byte per cycle; events leave one per cycle, while out_ready_i is high, from an
// eight-entry event queue, and a byte is taken while at least four queue entries are free.
// Reset (rst_ni low, asynchronous): tokenizer state and queue pointers cleared, no output valid.
`timescale 1ns / 1ps

module console_command_tokenizer_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] char_in_i,
  input  logic       text_last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] event_kind_o,
  output logic [7:0] char_out_o,
  output logic       run_last_o
);
  import cct_pkg::*;

  tok_state_t          state_q, state_d;
  evt_t [EvtMax-1:0]   evt;
  logic [EvtCntW-1:0]  evt_cnt;

  evt_t                fifo_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FifoCntW-1:0] count_q;
  logic                in_fire, out_fire;
  logic [EvtCntW-1:0]  wr_n;
  evt_t                head;

  cct_decode u_decode (
    .state_i      (state_q),
    .char_i       (char_in_i),
    .last_i       (text_last_i),
    .next_state_o (state_d),
    .evt_o        (evt),
    .evt_cnt_o    (evt_cnt)
  );

  // Take a word only when a full burst of events fits in the queue
  assign in_ready_o = (count_q <= FifoCntW'(FifoDepth - EvtMax));
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_fire   = out_valid_o && out_ready_i;
  assign wr_n       = in_fire ? evt_cnt : '0;

  // Advance tokenizer state on each accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (in_fire) begin
      state_q <= state_d;
    end
  end

  // Queue pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + FifoPtrW'(wr_n);
      if (out_fire) begin
        rd_ptr_q <= rd_ptr_q + FifoPtrW'(1);
      end
      count_q <= count_q + FifoCntW'(wr_n) - FifoCntW'(out_fire);
    end
  end

  // Write this word's events into consecutive queue entries
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < EvtMax; k++) begin
      if (in_fire && (EvtCntW'(k) < evt_cnt)) begin
        fifo_q[wr_ptr_q + FifoPtrW'(k)] <= evt[k];
      end
    end
  end

  // Present the queue head
  assign head         = fifo_q[rd_ptr_q];
  assign out_valid_o  = (count_q != '0);
  assign event_kind_o = head.kind;
  assign char_out_o   = head.ch;
  assign run_last_o   = head.last;

endmodule

// ----- hdl/cct_checker.sv -----
// Port-level checker for the console command tokenizer, bound to the top level.
// Depends on cct_pkg and console_command_tokenizer_top_macros.svh.
`timescale 1ns / 1ps
`include "console_command_tokenizer_top_macros.svh"

module cct_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [1:0] event_kind_o,
  input logic [7:0] char_out_o,
  input logic       run_last_o
);
  import cct_pkg::*;

  logic        end_evt;
  logic        cmd_end;
  logic        stall;
  logic [10:0] out_word;

  // Qualified views of the output word
  assign end_evt  = out_valid_o && (event_kind_o != KIND_CHAR);
  assign cmd_end  = out_valid_o && (event_kind_o == KIND_COMMAND_END);
  assign stall    = out_valid_o && !out_ready_i;
  assign out_word = {event_kind_o, char_out_o, run_last_o};

  // Only the three defined kinds leave the block
  `CCT_ASSERT(a_kind_legal, out_valid_o |-> (event_kind_o <= KIND_COMMAND_END), "undefined kind")

  // Token and command ends carry a zero byte
  `CCT_ASSERT(a_end_zero, end_evt |-> (char_out_o == 8'h00), "end event with nonzero byte")

  // A command end is always the final event of its word
  `CCT_ASSERT(a_cmd_end_last, cmd_end |-> run_last_o, "command end not last")

  // A stalled event holds until taken
  `CCT_ASSERT(a_out_hold, stall |=> (out_valid_o && $stable(out_word)), "stalled event changed")

endmodule

bind console_command_tokenizer_top cct_checker u_cct_checker (.*);

// ----- dv/console_command_tokenizer_checker.sv -----
// Checker for the console command tokenizer: predicts the event words of each text byte.
// Watches both channels of console_command_tokenizer_top; depends on cct_pkg.
`timescale 1ns / 1ps

module console_command_tokenizer_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  char_in_i,
  input  logic        text_last_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [1:0]  event_kind_i,
  input  logic [7:0]  char_out_i,
  input  logic        run_last_i,
  output int unsigned mismatch_count_o,
  output int unsigned expected_left_o
);
  import cct_pkg::*;

  // Tokenizer state as seen by the predictor
  logic in_quote;
  logic in_token;
  logic cmd_has_token;
  logic slash_held;
  logic in_comment;

  evt_t        expected_events[$];
  evt_t        byte_events[$];
  evt_t        head_evt;
  int unsigned mismatches;

  assign mismatch_count_o = mismatches;

  // Append one event word, at most four per byte
  task automatic add_event(input logic [1:0] kind, input logic [7:0] ch);
    evt_t e;
    e = '{kind: kind, ch: ch, last: 1'b0};
    if (byte_events.size() < EvtMax) begin
      byte_events.insert(byte_events.size(), e);
    end
  endtask

  task automatic close_token();
    if (in_token) begin
      add_event(KIND_TOKEN_END, 8'h00);
      cmd_has_token = 1'b1;
    end
    in_token = 1'b0;
  endtask

  task automatic close_command();
    close_token();
    if (cmd_has_token) begin
      add_event(KIND_COMMAND_END, 8'h00);
    end
    cmd_has_token = 1'b0;
  endtask

  // Handle a byte once slash and comment handling is settled
  task automatic take_plain(input logic [7:0] c);
    if (in_quote) begin
      if (c == CH_QUOTE || c == CH_NL) begin
        in_quote = 1'b0;
      end
      if (c == CH_NL) begin
        close_command();
      end else if (c != CH_QUOTE) begin
        add_event(KIND_CHAR, c);
      end
    end else if (c == CH_QUOTE) begin
      in_quote = 1'b1;
      in_token = 1'b1;
    end else if (c == CH_SEMI || c == CH_NL) begin
      close_command();
    end else if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
      close_token();
    end else begin
      add_event(KIND_CHAR, c);
      in_token = 1'b1;
    end
  endtask

  // Work out the event words of one accepted text byte
  task automatic predict_text_byte(input logic [7:0] c, input logic last);
    byte_events.delete();
    if (in_comment) begin
      if (c == CH_NL) begin
        in_comment = 1'b0;
        take_plain(c);
      end
    end else if (slash_held) begin
      slash_held = 1'b0;
      if (c == CH_SLASH) begin
        in_comment = 1'b1;
      end else begin
        add_event(KIND_CHAR, CH_SLASH);
        in_token = 1'b1;
        take_plain(c);
      end
    end else if (!in_quote && c == CH_SLASH && !last) begin
      slash_held = 1'b1;
    end else begin
      take_plain(c);
    end
    // Flush on the last byte and drop all state
    if (last) begin
      close_command();
      in_quote   = 1'b0;
      in_token   = 1'b0;
      slash_held = 1'b0;
      in_comment = 1'b0;
    end
    if (byte_events.size() != 0) begin
      byte_events[byte_events.size() - 1].last = 1'b1;
    end
    foreach (byte_events[i]) begin
      expected_events.insert(expected_events.size(), byte_events[i]);
    end
  endtask

  // Compare output words first, then predict from the accepted input word
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_quote        = 1'b0;
      in_token        = 1'b0;
      cmd_has_token   = 1'b0;
      slash_held      = 1'b0;
      in_comment      = 1'b0;
      mismatches      = 0;
      expected_events.delete();
      expected_left_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_events.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected word: expected none, actual kind %0d char %02h last %0b",
                   $time, event_kind_i, char_out_i, run_last_i);
        end else begin
          head_evt = expected_events.pop_front();
          if (event_kind_i !== head_evt.kind) begin
            mismatches++;
            $display("%0t: event_kind: expected %0d, actual %0d",
                     $time, head_evt.kind, event_kind_i);
          end
          if (char_out_i !== head_evt.ch) begin
            mismatches++;
            $display("%0t: char_out: expected %02h, actual %02h",
                     $time, head_evt.ch, char_out_i);
          end
          if (run_last_i !== head_evt.last) begin
            mismatches++;
            $display("%0t: run_last: expected %0b, actual %0b",
                     $time, head_evt.last, run_last_i);
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        predict_text_byte(char_in_i, text_last_i);
      end
      expected_left_o = expected_events.size();
    end
  end

endmodule

// ----- dv/tb.sv -----
// Testbench top for console_command_tokenizer_top: drives text bytes and drains event words.
// Depends on cct_pkg, the block and console_command_tokenizer_checker.
`timescale 1ns / 1ps

module tb;
  import cct_pkg::*;

  localparam int WatchdogLimit  = 3000;
  localparam int LongHoldCycles = 90;
  localparam int DrainCycles    = 20;

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } text_byte_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [7:0] char_in_i;
  logic       text_last_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [1:0] event_kind_o;
  logic [7:0] char_out_o;
  logic       run_last_o;

  int unsigned mismatch_count;
  int unsigned expected_left;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int          quiet_cycles = 0;
  logic        hold_armed;
  logic        hold_done;
  text_byte_t  text_q[$];

  console_command_tokenizer_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .char_in_i    (char_in_i),
    .text_last_i  (text_last_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .event_kind_o (event_kind_o),
    .char_out_o   (char_out_o),
    .run_last_o   (run_last_o)
  );

  console_command_tokenizer_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .char_in_i        (char_in_i),
    .text_last_i      (text_last_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .event_kind_i     (event_kind_o),
    .char_out_i       (char_out_o),
    .run_last_i       (run_last_o),
    .mismatch_count_o (mismatch_count),
    .expected_left_o  (expected_left)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Receiver: random back-pressure, plus one long hold-off once armed
  initial begin
    out_ready_i = 1'b0;
    hold_done   = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_armed && !hold_done) begin
        out_ready_i <= 1'b0;
        repeat (LongHoldCycles) @(negedge clk_i);
        hold_done = 1'b1;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: end the run once nothing has moved for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WatchdogLimit) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_byte(input logic [7:0] ch, input logic last);
    text_byte_t b;
    b.ch   = ch;
    b.last = last;
    text_q.insert(text_q.size(), b);
  endtask

  task automatic queue_text(input string s, input logic last_at_end);
    for (int i = 0; i < s.len(); i++) begin
      queue_byte(s[i], last_at_end && (i == s.len() - 1));
    end
  endtask

  // Random byte, now and then flagged as the end of the text
  task automatic queue_rand(input logic [7:0] ch);
    queue_byte(ch, $urandom_range(39) == 0);
  endtask

  function automatic logic [7:0] token_char();
    if ($urandom_range(99) < 85) begin
      return 8'h61 + 8'($urandom_range(25));
    end
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [7:0] blank_char();
    case ($urandom_range(4))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return 8'h0B;
      3: return 8'h0C;
      default: return CH_CR;
    endcase
  endfunction

  // Build mostly well-formed commands with random content, plus some noise
  task automatic add_random_text(input int n);
    int start;
    int pick;
    start = text_q.size();
    while (text_q.size() - start < n) begin
      pick = $urandom_range(99);
      if (pick < 38) begin
        repeat ($urandom_range(5, 1)) queue_rand(token_char());
      end else if (pick < 55) begin
        queue_rand(blank_char());
      end else if (pick < 67) begin
        queue_rand($urandom_range(1) ? CH_SEMI : CH_NL);
      end else if (pick < 77) begin
        queue_rand(CH_QUOTE);
        repeat ($urandom_range(4)) begin
          case ($urandom_range(3))
            0: queue_rand(CH_SPACE);
            1: queue_rand(CH_SLASH);
            default: queue_rand(token_char());
          endcase
        end
        queue_rand(($urandom_range(5) == 0) ? CH_NL : CH_QUOTE);
      end else if (pick < 84) begin
        queue_rand(CH_SLASH);
        queue_rand(CH_SLASH);
        repeat ($urandom_range(3)) queue_rand(($urandom_range(2) == 0) ? CH_SEMI : token_char());
        queue_rand(CH_NL);
      end else if (pick < 90) begin
        queue_rand(CH_SLASH);
        queue_rand(token_char());
      end else begin
        queue_rand(8'($urandom_range(255)));
      end
    end
  endtask

  // Offer every queued byte, holding valid and payload until taken
  task automatic send_text();
    text_byte_t b;
    while (text_q.size() != 0) begin
      b = text_q.pop_front();
      if ($urandom_range(99) < send_idle_pct) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        repeat ($urandom_range(4)) @(negedge clk_i);
      end
      @(negedge clk_i);
      in_valid_i  <= 1'b1;
      char_in_i   <= b.ch;
      text_last_i <= b.last;
      @(posedge clk_i);
      while (!in_ready_o) @(posedge clk_i);
    end
  endtask

  // Stop offering and wait for every expected word to come out
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_left != 0) @(negedge clk_i);
  endtask

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    char_in_i     = 8'h00;
    text_last_i   = 1'b0;
    hold_armed    = 1'b0;
    send_idle_pct = 13;
    recv_idle_pct = 77;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Tab, empty quotes, slash and newline inside quotes
    queue_text("a\t\"\";", 1'b0);
    queue_text("\"p /q\n", 1'b0);
    // Comment inside a token, closed by a newline
    queue_text("k//z\n", 1'b0);
    // Slash then other byte, slash as the final byte
    queue_text("/x/", 1'b1);
    // Byte extremes and vertical tab / carriage return
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h0B, 1'b0);
    queue_byte(8'h0D, 1'b0);
    // Final flag while a comment is open
    queue_text("w//", 1'b1);
    add_random_text(62);
    send_text();
    wait_drained();

    send_idle_pct = 77;
    recv_idle_pct = 13;
    add_random_text(66);
    send_text();
    wait_drained();

    // Full rate, with one long receiver hold-off to fill the block
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_armed    = 1'b1;
    add_random_text(66);
    send_text();
    wait_drained();

    repeat (DrainCycles) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
